>>> hw/rtl/nbt_pkg.sv
package nbt_pkg;

    localparam int unsigned DefaultMaxDepth = 16;

    localparam logic [3:0] TAG_END       = 4'd0;
    localparam logic [3:0] TAG_BYTE      = 4'd1;
    localparam logic [3:0] TAG_SHORT     = 4'd2;
    localparam logic [3:0] TAG_INT       = 4'd3;
    localparam logic [3:0] TAG_LONG      = 4'd4;
    localparam logic [3:0] TAG_FLOAT     = 4'd5;
    localparam logic [3:0] TAG_DOUBLE    = 4'd6;
    localparam logic [3:0] TAG_BYTE_ARR  = 4'd7;
    localparam logic [3:0] TAG_STRING    = 4'd8;
    localparam logic [3:0] TAG_LIST      = 4'd9;
    localparam logic [3:0] TAG_COMPOUND  = 4'd10;
    localparam logic [3:0] TAG_INT_ARR   = 4'd11;
    localparam logic [3:0] TAG_LONG_ARR  = 4'd12;
    localparam logic [3:0] TAG_UNKNOWN   = 4'd15;

    localparam logic [3:0] ROLE_TAG_ID   = 4'd0;
    localparam logic [3:0] ROLE_NAME_LEN = 4'd1;
    localparam logic [3:0] ROLE_NAME_CHR = 4'd2;
    localparam logic [3:0] ROLE_LIST_TAG = 4'd3;
    localparam logic [3:0] ROLE_COUNT    = 4'd4;
    localparam logic [3:0] ROLE_VALUE    = 4'd5;
    localparam logic [3:0] ROLE_CONTENT  = 4'd6;
    localparam logic [3:0] ROLE_CMP_END  = 4'd7;
    localparam logic [3:0] ROLE_IGNORED  = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_document;
    } nbt_in_t;

    typedef struct packed {
        logic [3:0]  role;
        logic [3:0]  tag_type;
        logic [4:0]  depth;
        logic [63:0] value;
        logic        value_done;
        logic        item_done;
        logic        error;
        logic        document_done;
    } nbt_out_t;

    // One nesting level: list or compound, list element tag, elements left.
    typedef struct packed {
        logic        is_list;
        logic [3:0]  elem_tag;
        logic [31:0] count;
    } nbt_frame_t;

    function automatic logic [3:0] map_tag(input logic [7:0] b);
        map_tag = (b <= 8'd12) ? b[3:0] : TAG_UNKNOWN;
    endfunction

    function automatic logic [3:0] scalar_bytes(input logic [3:0] t);
        case (t)
            TAG_BYTE:   scalar_bytes = 4'd1;
            TAG_SHORT:  scalar_bytes = 4'd2;
            TAG_INT:    scalar_bytes = 4'd4;
            TAG_LONG:   scalar_bytes = 4'd8;
            TAG_FLOAT:  scalar_bytes = 4'd4;
            TAG_DOUBLE: scalar_bytes = 4'd8;
            default:    scalar_bytes = 4'd0;
        endcase
    endfunction

endpackage

>>> hw/rtl/nbt_stream_parser.sv
// Channel  | Ports                       | Payload       | Direction
// ---------+-----------------------------+---------------+----------
// input    | s_valid, s_ready, s_item    | nbt_in_t      | in
// result   | m_valid, m_ready, m_item    | nbt_out_t     | out
//
// One byte per cycle while m_ready stays high: a transaction is taken into
// the input register, parsed once the output register is free or emptying,
// and its result lands in the output register, which drives m_valid; the
// sustained rate is one byte per clock without back-pressure.
// The rate is set by the single parse step on the top-of-stack frame.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to expecting a root tag. When m_ready is low, a held result and
// any held byte stay put, and s_ready drops while both registers are full.
module nbt_stream_parser #(
    parameter int unsigned MAX_DEPTH = nbt_pkg::DefaultMaxDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nbt_pkg::nbt_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output nbt_pkg::nbt_out_t m_item
);

    logic              in_vld_reg, in_vld_next;
    nbt_pkg::nbt_in_t  in_item_reg;
    logic              out_vld_reg, out_vld_next;
    nbt_pkg::nbt_out_t out_item_reg;
    nbt_pkg::nbt_out_t step_result;
    logic              step_en;

    // The held byte is parsed once the output register is free or emptying.
    assign step_en     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready     = !in_vld_reg || step_en;
    assign in_vld_next = (s_valid && s_ready) || (in_vld_reg && !step_en);
    assign out_vld_next = step_en || (out_vld_reg && !m_ready);

    nbt_parse_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .in_item  (in_item_reg),
        .out_item (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (step_en) begin
            out_item_reg <= step_result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_item  = out_item_reg;

endmodule

>>> hw/rtl/nbt_frame_stack.sv
module nbt_frame_stack #(
    parameter int unsigned MAX_DEPTH = nbt_pkg::DefaultMaxDepth,
    parameter int unsigned LW = $clog2(MAX_DEPTH + 1),
    parameter int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               wa_en,
    input  logic [IW-1:0]      wa_idx,
    input  nbt_pkg::nbt_frame_t wa_frame,
    input  logic               wb_en,
    input  logic [IW-1:0]      wb_idx,
    input  nbt_pkg::nbt_frame_t wb_frame,
    input  logic [LW-1:0]      search_lim,
    output logic               found,
    output logic [IW-1:0]      found_idx,
    output nbt_pkg::nbt_frame_t found_frame
);

    nbt_pkg::nbt_frame_t frame_reg [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] empty_list_reg;

    always_ff @(posedge aclk) begin
        if (wa_en) begin
            frame_reg[wa_idx]      <= wa_frame;
            empty_list_reg[wa_idx] <= wa_frame.is_list && (wa_frame.count == 32'd0);
        end
        if (wb_en) begin
            frame_reg[wb_idx]      <= wb_frame;
            empty_list_reg[wb_idx] <= wb_frame.is_list && (wb_frame.count == 32'd0);
        end
    end

    // Highest frame below the limit that is not an exhausted list.
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((LW'(i) < search_lim) && !empty_list_reg[i]) begin
                found     = 1'b1;
                found_idx = IW'(i);
            end
        end
    end

    assign found_frame = frame_reg[found_idx];

endmodule

>>> hw/rtl/nbt_parse_core.sv
module nbt_parse_core #(
    parameter int unsigned MAX_DEPTH = nbt_pkg::DefaultMaxDepth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  nbt_pkg::nbt_in_t in_item,
    output nbt_pkg::nbt_out_t out_item
);

    localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [3:0] {
        M_ROOT, M_NAMELEN, M_NAMECHR, M_LISTTAG, M_COUNT,
        M_SCALAR, M_CONTENT, M_ELEM, M_CTAG, M_DONE, M_ERR
    } mode_t;

    mode_t       mode_reg, mode_next, mode_c;
    logic [3:0]  cur_reg, cur_next, cur_c;
    logic [3:0]  fbl_reg, fbl_next, fbl_c, fbl_dec;
    logic [31:0] pl_reg, pl_next, pl_c, pl_shift, pl_dec;
    logic [63:0] acc_reg, acc_next, acc_c, acc_shift;
    logic [LW-1:0] lvl_reg, lvl_next, lvl_c;
    logic        err_reg, err_next, err_c;

    logic [7:0]  b;
    logic [3:0]  tag_b;

    logic        do_adv, vf_en, do_bp;
    logic [LW-1:0] adv_base, bp_lvl, search_lim;
    logic [3:0]  bp_tag;
    nbt_pkg::nbt_frame_t vf;

    logic        wa_en, wb_en;
    logic [IW-1:0] wa_idx, wb_idx;
    nbt_pkg::nbt_frame_t wa_frame, wb_frame;
    logic        found;
    logic [IW-1:0] found_idx;
    nbt_pkg::nbt_frame_t found_frame;

    nbt_frame_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .aclk        (aclk),
        .wa_en       (wa_en && step_en),
        .wa_idx      (wa_idx),
        .wa_frame    (wa_frame),
        .wb_en       (wb_en && step_en),
        .wb_idx      (wb_idx),
        .wb_frame    (wb_frame),
        .search_lim  (search_lim),
        .found       (found),
        .found_idx   (found_idx),
        .found_frame (found_frame)
    );

    assign b     = in_item.data_byte;
    assign tag_b = nbt_pkg::map_tag(b);

    always_comb begin
        // A document start acts on the state as a reset before the byte.
        if (in_item.start_of_document) begin
            mode_c = M_ROOT;
            cur_c  = 4'd0;
            fbl_c  = 4'd0;
            pl_c   = 32'd0;
            acc_c  = 64'd0;
            lvl_c  = '0;
            err_c  = 1'b0;
        end else begin
            mode_c = mode_reg;
            cur_c  = cur_reg;
            fbl_c  = fbl_reg;
            pl_c   = pl_reg;
            acc_c  = acc_reg;
            lvl_c  = lvl_reg;
            err_c  = err_reg;
        end
        fbl_dec   = fbl_c - 4'd1;
        pl_shift  = {pl_c[23:0], b};
        pl_dec    = (pl_c != 32'd0) ? (pl_c - 32'd1) : pl_c;
        acc_shift = {acc_c[55:0], b};

        mode_next = mode_c;
        cur_next  = cur_c;
        fbl_next  = fbl_c;
        pl_next   = pl_c;
        acc_next  = acc_c;
        lvl_next  = lvl_c;
        err_next  = err_c;

        out_item               = '0;
        out_item.role          = nbt_pkg::ROLE_IGNORED;
        out_item.tag_type      = cur_c;
        out_item.depth         = 5'(lvl_c);

        do_adv     = 1'b0;
        adv_base   = lvl_c;
        vf_en      = 1'b0;
        vf         = '0;
        do_bp      = 1'b0;
        bp_tag     = cur_c;
        bp_lvl     = lvl_c;
        search_lim = lvl_c;
        wa_en      = 1'b0;
        wa_idx     = '0;
        wa_frame   = '0;
        wb_en      = 1'b0;
        wb_idx     = '0;
        wb_frame   = '0;

        case (mode_c)
            M_ROOT: begin
                out_item.role     = nbt_pkg::ROLE_TAG_ID;
                out_item.tag_type = tag_b;
                cur_next  = tag_b;
                mode_next = M_NAMELEN;
                fbl_next  = 4'd2;
                pl_next   = 32'd0;
            end
            M_CTAG: begin
                if (b == 8'd0) begin
                    out_item.role      = nbt_pkg::ROLE_CMP_END;
                    out_item.tag_type  = nbt_pkg::TAG_COMPOUND;
                    out_item.item_done = 1'b1;
                    adv_base = (lvl_c != '0) ? (lvl_c - LW'(1)) : lvl_c;
                    do_adv   = 1'b1;
                end else begin
                    out_item.role     = nbt_pkg::ROLE_TAG_ID;
                    out_item.tag_type = tag_b;
                    cur_next  = tag_b;
                    mode_next = M_NAMELEN;
                    fbl_next  = 4'd2;
                    pl_next   = 32'd0;
                end
            end
            M_NAMELEN: begin
                out_item.role = nbt_pkg::ROLE_NAME_LEN;
                pl_next  = pl_shift;
                fbl_next = fbl_dec;
                if (fbl_dec == 4'd0) begin
                    if (pl_shift == 32'd0) do_bp = 1'b1;
                    else mode_next = M_NAMECHR;
                end
            end
            M_NAMECHR: begin
                out_item.role = nbt_pkg::ROLE_NAME_CHR;
                pl_next = pl_dec;
                if (pl_dec == 32'd0) do_bp = 1'b1;
            end
            M_LISTTAG: begin
                out_item.role = nbt_pkg::ROLE_LIST_TAG;
                acc_next  = {60'd0, tag_b};
                mode_next = M_COUNT;
                fbl_next  = 4'd4;
                pl_next   = 32'd0;
            end
            M_COUNT: begin
                out_item.role = nbt_pkg::ROLE_COUNT;
                pl_next  = pl_shift;
                fbl_next = fbl_dec;
                if (fbl_dec == 4'd0) begin
                    if (cur_c == nbt_pkg::TAG_LIST) begin
                        if (lvl_c >= LW'(MAX_DEPTH)) begin
                            err_next  = 1'b1;
                            mode_next = M_ERR;
                        end else begin
                            vf_en      = 1'b1;
                            vf.is_list = 1'b1;
                            vf.elem_tag = acc_c[3:0];
                            vf.count   = pl_shift;
                            adv_base   = lvl_c + LW'(1);
                            do_adv     = 1'b1;
                        end
                    end else if (pl_shift == 32'd0) begin
                        out_item.item_done = 1'b1;
                        do_adv = 1'b1;
                    end else if (cur_c == nbt_pkg::TAG_INT_ARR ||
                                 cur_c == nbt_pkg::TAG_LONG_ARR) begin
                        mode_next = M_ELEM;
                        fbl_next  = (cur_c == nbt_pkg::TAG_INT_ARR) ? 4'd4 : 4'd8;
                        acc_next  = 64'd0;
                    end else begin
                        mode_next = M_CONTENT;
                    end
                end
            end
            M_SCALAR: begin
                out_item.role = nbt_pkg::ROLE_VALUE;
                acc_next = acc_shift;
                fbl_next = fbl_dec;
                if (fbl_dec == 4'd0) begin
                    out_item.value_done = 1'b1;
                    out_item.value      = acc_shift;
                    out_item.item_done  = 1'b1;
                    do_adv = 1'b1;
                end
            end
            M_CONTENT: begin
                out_item.role = nbt_pkg::ROLE_CONTENT;
                if (cur_c == nbt_pkg::TAG_BYTE_ARR) begin
                    out_item.value_done = 1'b1;
                    out_item.value      = {56'd0, b};
                end
                pl_next = pl_dec;
                if (pl_dec == 32'd0) begin
                    out_item.item_done = 1'b1;
                    do_adv = 1'b1;
                end
            end
            M_ELEM: begin
                out_item.role = nbt_pkg::ROLE_VALUE;
                acc_next = acc_shift;
                fbl_next = fbl_dec;
                if (fbl_dec == 4'd0) begin
                    out_item.value_done = 1'b1;
                    out_item.value      = acc_shift;
                    pl_next = pl_dec;
                    if (pl_dec == 32'd0) begin
                        out_item.item_done = 1'b1;
                        do_adv = 1'b1;
                    end else begin
                        fbl_next = (cur_c == nbt_pkg::TAG_INT_ARR) ? 4'd4 : 4'd8;
                        acc_next = 64'd0;
                    end
                end
            end
            default: begin
                out_item.tag_type = 4'd0;
            end
        endcase

        // Close out finished items: pop exhausted lists, then resume the
        // enclosing compound, start a list element or end the document.
        if (do_adv) begin
            if (vf_en && (vf.count != 32'd0)) begin
                wa_en          = 1'b1;
                wa_idx         = IW'(lvl_c);
                wa_frame       = vf;
                wa_frame.count = vf.count - 32'd1;
                lvl_next       = adv_base;
                do_bp          = 1'b1;
                bp_tag         = vf.elem_tag;
                bp_lvl         = adv_base;
            end else begin
                search_lim = vf_en ? lvl_c : adv_base;
                if (vf_en) out_item.item_done = 1'b1;
                if (!found) begin
                    if (search_lim != '0) out_item.item_done = 1'b1;
                    mode_next              = M_DONE;
                    out_item.document_done = 1'b1;
                    lvl_next               = '0;
                end else begin
                    if ((LW'(found_idx) + LW'(1)) < search_lim) out_item.item_done = 1'b1;
                    lvl_next = LW'(found_idx) + LW'(1);
                    if (!found_frame.is_list) begin
                        mode_next = M_CTAG;
                        cur_next  = nbt_pkg::TAG_COMPOUND;
                    end else begin
                        wa_en          = 1'b1;
                        wa_idx         = found_idx;
                        wa_frame       = found_frame;
                        wa_frame.count = found_frame.count - 32'd1;
                        do_bp          = 1'b1;
                        bp_tag         = found_frame.elem_tag;
                        bp_lvl         = LW'(found_idx) + LW'(1);
                    end
                end
            end
        end

        if (do_bp) begin
            cur_next = bp_tag;
            case (bp_tag)
                nbt_pkg::TAG_BYTE, nbt_pkg::TAG_SHORT, nbt_pkg::TAG_INT,
                nbt_pkg::TAG_LONG, nbt_pkg::TAG_FLOAT, nbt_pkg::TAG_DOUBLE: begin
                    mode_next = M_SCALAR;
                    fbl_next  = nbt_pkg::scalar_bytes(bp_tag);
                    acc_next  = 64'd0;
                end
                nbt_pkg::TAG_BYTE_ARR, nbt_pkg::TAG_INT_ARR, nbt_pkg::TAG_LONG_ARR: begin
                    mode_next = M_COUNT;
                    fbl_next  = 4'd4;
                    pl_next   = 32'd0;
                end
                nbt_pkg::TAG_STRING: begin
                    mode_next = M_COUNT;
                    fbl_next  = 4'd2;
                    pl_next   = 32'd0;
                end
                nbt_pkg::TAG_LIST: begin
                    mode_next = M_LISTTAG;
                end
                nbt_pkg::TAG_COMPOUND: begin
                    if (bp_lvl >= LW'(MAX_DEPTH)) begin
                        err_next  = 1'b1;
                        mode_next = M_ERR;
                    end else begin
                        wb_en     = 1'b1;
                        wb_idx    = IW'(bp_lvl);
                        wb_frame  = '0;
                        lvl_next  = bp_lvl + LW'(1);
                        mode_next = M_CTAG;
                    end
                end
                default: begin
                    err_next  = 1'b1;
                    mode_next = M_ERR;
                end
            endcase
        end

        out_item.error = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_ROOT;
            cur_reg  <= 4'd0;
            fbl_reg  <= 4'd0;
            pl_reg   <= 32'd0;
            acc_reg  <= 64'd0;
            lvl_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            cur_reg  <= cur_next;
            fbl_reg  <= fbl_next;
            pl_reg   <= pl_next;
            acc_reg  <= acc_next;
            lvl_reg  <= lvl_next;
            err_reg  <= err_next;
        end
    end

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg && step_en && !in_item.start_of_document) |=> err_reg)
        else $error("error flag cleared without a document start");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LW'(MAX_DEPTH))
        else $error("stack level beyond its depth");

    a_doc_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && out_item.document_done) |=> (lvl_reg == '0 && mode_reg == M_DONE))
        else $error("document ended with frames still open");

    a_err_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == M_ERR) |-> err_reg)
        else $error("error mode without error flag");

endmodule
